### rtl/detection_proposal_decode_defines.svh
// ----------------------------------------------------------------------------
// Detection proposal decode: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DETECTION_PROPOSAL_DECODE_DEFINES_SVH
`define DETECTION_PROPOSAL_DECODE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define DPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define DPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// Detection proposal decode package
// Field widths, payload types, register indexes and reset values.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 16;
    localparam int CLASS_W    = 8;
    localparam int SCORE_W    = 31;
    localparam int IDX_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int THRESH_W   = 17;
    localparam int PAD_W      = 10;
    localparam int RATIO_W    = 24;

    // box values at the head of each row: cx, cy, w, h
    localparam int BOX_VALUES = 4;

    typedef logic signed [VALUE_W-1:0]    value_t;
    typedef logic signed [COORD_W-1:0]    coord_t;
    typedef logic        [CLASS_W-1:0]    class_t;
    typedef logic        [SCORE_W-1:0]    score_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_CONF_THRESHOLD = 3'd0;
    localparam cfg_idx_t REG_PAD_W          = 3'd1;
    localparam cfg_idx_t REG_PAD_H          = 3'd2;
    localparam cfg_idx_t REG_RATIO_W        = 3'd3;
    localparam cfg_idx_t REG_RATIO_H        = 3'd4;
    localparam cfg_idx_t REG_NUM_CLASSES    = 3'd5;

    localparam logic [THRESH_W-1:0] RST_CONF_THRESHOLD = 17'd45875;
    localparam logic [PAD_W-1:0]    RST_PAD            = 10'd0;
    localparam logic [RATIO_W-1:0]  RST_RATIO          = 24'd65536;
    localparam logic [CLASS_W-1:0]  RST_NUM_CLASSES    = 8'd80;

    localparam int COORD_MAX = 32767;
    localparam int COORD_MIN = -32768;

endpackage

### rtl/dpd_in_if.sv
// ----------------------------------------------------------------------------
// Detection proposal decode: input stream channel
// One signed Q16.16 row element per request.
// ----------------------------------------------------------------------------
interface dpd_in_if import dpd_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);

endinterface

### rtl/dpd_out_if.sv
// ----------------------------------------------------------------------------
// Detection proposal decode: result channel
// One kept detection per request: box in frame pixels, class and score.
// ----------------------------------------------------------------------------
interface dpd_out_if import dpd_pkg::*; ();

    logic   valid;
    logic   ready;
    coord_t left;
    coord_t top;
    coord_t box_width;
    coord_t box_height;
    class_t class_id;
    score_t score;

    modport source (output valid, left, top, box_width, box_height, class_id, score,
                    input ready);
    modport sink   (input valid, left, top, box_width, box_height, class_id, score,
                    output ready);

endinterface

### rtl/dpd_cfg_if.sv
// ----------------------------------------------------------------------------
// Detection proposal decode: configuration write channel
// Register index and write data per request.
// ----------------------------------------------------------------------------
interface dpd_cfg_if import dpd_pkg::*; ();

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

### rtl/detection_proposal_decode.sv
// ----------------------------------------------------------------------------
// Detection proposal decode
// Streams detector rows (cx, cy, w, h, class scores), keeps a running argmax
// and emits the letterbox-corrected, scaled box when the best score passes
// the threshold. Takes one value per cycle while the capture stage is free; a
// kept row's result leaves through a capture, multiply, combine and
// round/saturate pipeline into the output register, in which every
// stage holds under output backpressure. Configuration writes are always
// ready and must be issued only while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "detection_proposal_decode_defines.svh"

module detection_proposal_decode
    import dpd_pkg::*;
#(
    parameter int MAX_CLASSES = 255,
    parameter int FRAC_BITS   = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    dpd_cfg_if.sink         cfg,
    dpd_in_if.sink          sample,
    dpd_out_if.source       result
);

    localparam int PROD_W   = VALUE_W + RATIO_W + 1;
    localparam int PADP_W   = PAD_W + RATIO_W;
    localparam int PADS_W   = PADP_W + FRAC_BITS + 2;
    localparam int L2_BASE  = (PROD_W + 1 > PADS_W) ? PROD_W + 1 : PADS_W;
    localparam int L2_W     = L2_BASE + 2;
    localparam int EDGE_SH  = 2 * FRAC_BITS + 1;
    localparam int SIZE_SH  = 2 * FRAC_BITS;

    localparam logic [L2_W-1:0] EDGE_MASK = {{(L2_W - EDGE_SH){1'b0}}, {EDGE_SH{1'b1}}};
    localparam logic [L2_W-1:0] SIZE_MASK = {{(L2_W - SIZE_SH){1'b0}}, {SIZE_SH{1'b1}}};
    localparam logic signed [L2_W-1:0] SAT_HI = L2_W'(COORD_MAX);
    localparam logic signed [L2_W-1:0] SAT_LO = L2_W'(COORD_MIN);
    localparam logic [CLASS_W-1:0] MAX_NC = CLASS_W'(MAX_CLASSES);

    function automatic coord_t sat16(input logic signed [L2_W-1:0] q);
        coord_t r;
        if (q > SAT_HI)
            r = COORD_W'(COORD_MAX);
        else if (q < SAT_LO)
            r = COORD_W'(COORD_MIN);
        else
            r = q[COORD_W-1:0];
        return r;
    endfunction

    function automatic coord_t trunc_edge(input logic signed [L2_W-1:0] x);
        logic signed [L2_W-1:0] b;
        b = x + $signed(x[L2_W-1] ? EDGE_MASK : {L2_W{1'b0}});
        return sat16(b >>> EDGE_SH);
    endfunction

    function automatic coord_t trunc_size(input logic signed [L2_W-1:0] x);
        logic signed [L2_W-1:0] b;
        b = x + $signed(x[L2_W-1] ? SIZE_MASK : {L2_W{1'b0}});
        return sat16(b >>> SIZE_SH);
    endfunction

    // configuration
    logic [THRESH_W-1:0] conf_threshold_reg;
    logic [PAD_W-1:0]    pad_w_reg;
    logic [PAD_W-1:0]    pad_h_reg;
    logic [RATIO_W-1:0]  ratio_w_reg;
    logic [RATIO_W-1:0]  ratio_h_reg;
    logic [CLASS_W-1:0]  num_classes_reg;

    // row state
    logic [IDX_W-1:0] elem_idx_reg,   elem_idx_next;
    value_t           best_score_reg, best_score_next;
    class_t           best_class_reg, best_class_next;
    value_t           center_x_reg,   center_x_next;
    value_t           center_y_reg,   center_y_next;
    value_t           raw_width_reg,  raw_width_next;
    value_t           raw_height_reg, raw_height_next;

    // pipeline
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, o_valid_reg;
    logic   s1_free, s2_free, s3_free, o_free;
    logic   acc, row_end, keep;
    logic [CLASS_W-1:0] nc;
    logic [IDX_W-1:0]   last_idx;

    value_t s1_cx_reg, s1_cy_reg, s1_w_reg, s1_h_reg, s1_score_reg;
    class_t s1_class_reg;

    logic signed [PROD_W-1:0] s2_px_reg, s2_py_reg, s2_pw_reg, s2_ph_reg;
    logic signed [PROD_W-1:0] px_next, py_next, pw_next, ph_next;
    logic [PADP_W-1:0]        s2_padx_reg, s2_pady_reg, padx_next, pady_next;
    class_t                   s2_class_reg;
    score_t                   s2_score_reg;

    logic signed [L2_W-1:0]   s3_l2_reg, s3_t2_reg, l2_next, t2_next;
    logic signed [PROD_W-1:0] s3_w_reg, s3_h_reg;
    class_t                   s3_class_reg;
    score_t                   s3_score_reg;

    coord_t o_left_reg, o_top_reg, o_width_reg, o_height_reg;
    class_t o_class_reg;
    score_t o_score_reg;

    assign o_free  = !o_valid_reg || result.ready;
    assign s3_free = !s3_valid_reg || o_free;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;

    assign sample.ready = s1_free;
    assign cfg.ready    = 1'b1;
    assign acc          = sample.valid && s1_free;

    assign nc       = (num_classes_reg > MAX_NC) ? MAX_NC : num_classes_reg;
    assign last_idx = IDX_W'(nc) + IDX_W'(BOX_VALUES - 1);
    assign row_end  = elem_idx_reg >= last_idx;

    always_comb
    begin
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;
        raw_width_next  = raw_width_reg;
        raw_height_next = raw_height_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        if (elem_idx_reg < IDX_W'(BOX_VALUES))
        begin
            unique case (elem_idx_reg[1:0])
                2'd0:    center_x_next   = sample.value;
                2'd1:    center_y_next   = sample.value;
                2'd2:    raw_width_next  = sample.value;
                default: raw_height_next = sample.value;
            endcase
        end
        else if (sample.value > best_score_reg)
        begin
            best_score_next = sample.value;
            best_class_next = CLASS_W'(elem_idx_reg - IDX_W'(BOX_VALUES));
        end
        elem_idx_next = row_end ? '0 : elem_idx_reg + 1'b1;
    end

    assign keep = $signed({s1_score_reg[VALUE_W-1], s1_score_reg})
                  >= $signed({{(VALUE_W + 1 - THRESH_W){1'b0}}, conf_threshold_reg});

    assign px_next   = s1_cx_reg * $signed({1'b0, ratio_w_reg});
    assign py_next   = s1_cy_reg * $signed({1'b0, ratio_h_reg});
    assign pw_next   = s1_w_reg  * $signed({1'b0, ratio_w_reg});
    assign ph_next   = s1_h_reg  * $signed({1'b0, ratio_h_reg});
    assign padx_next = pad_w_reg * ratio_w_reg;
    assign pady_next = pad_h_reg * ratio_h_reg;

    // 2*cx - w, with cx = center*ratio - (pad*ratio << F)
    assign l2_next = (L2_W'(s2_px_reg) <<< 1) - L2_W'(s2_pw_reg)
                     - $signed(L2_W'(s2_padx_reg) << (FRAC_BITS + 1));
    assign t2_next = (L2_W'(s2_py_reg) <<< 1) - L2_W'(s2_ph_reg)
                     - $signed(L2_W'(s2_pady_reg) << (FRAC_BITS + 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_threshold_reg <= RST_CONF_THRESHOLD;
            pad_w_reg          <= RST_PAD;
            pad_h_reg          <= RST_PAD;
            ratio_w_reg        <= RST_RATIO;
            ratio_h_reg        <= RST_RATIO;
            num_classes_reg    <= RST_NUM_CLASSES;
            elem_idx_reg       <= '0;
            best_score_reg     <= '0;
            best_class_reg     <= '0;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
            o_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_CONF_THRESHOLD: conf_threshold_reg <= cfg.data[THRESH_W-1:0];
                    REG_PAD_W:          pad_w_reg          <= cfg.data[PAD_W-1:0];
                    REG_PAD_H:          pad_h_reg          <= cfg.data[PAD_W-1:0];
                    REG_RATIO_W:        ratio_w_reg        <= cfg.data[RATIO_W-1:0];
                    REG_RATIO_H:        ratio_h_reg        <= cfg.data[RATIO_W-1:0];
                    REG_NUM_CLASSES:    num_classes_reg    <= cfg.data[CLASS_W-1:0];
                    default:            ;
                endcase
            end
            if (acc)
            begin
                elem_idx_reg   <= elem_idx_next;
                best_score_reg <= row_end ? '0 : best_score_next;
                best_class_reg <= row_end ? '0 : best_class_next;
            end
            if (s1_free)
                s1_valid_reg <= acc && row_end;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg && keep;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (o_free)
                o_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
            raw_width_reg  <= raw_width_next;
            raw_height_reg <= raw_height_next;
        end
        if (s1_free)
        begin
            s1_cx_reg    <= center_x_next;
            s1_cy_reg    <= center_y_next;
            s1_w_reg     <= raw_width_next;
            s1_h_reg     <= raw_height_next;
            s1_score_reg <= best_score_next;
            s1_class_reg <= best_class_next;
        end
        if (s2_free)
        begin
            s2_px_reg    <= px_next;
            s2_py_reg    <= py_next;
            s2_pw_reg    <= pw_next;
            s2_ph_reg    <= ph_next;
            s2_padx_reg  <= padx_next;
            s2_pady_reg  <= pady_next;
            s2_class_reg <= s1_class_reg;
            s2_score_reg <= s1_score_reg[SCORE_W-1:0];
        end
        if (s3_free)
        begin
            s3_l2_reg    <= l2_next;
            s3_t2_reg    <= t2_next;
            s3_w_reg     <= s2_pw_reg;
            s3_h_reg     <= s2_ph_reg;
            s3_class_reg <= s2_class_reg;
            s3_score_reg <= s2_score_reg;
        end
        if (o_free)
        begin
            o_left_reg   <= trunc_edge(s3_l2_reg);
            o_top_reg    <= trunc_edge(s3_t2_reg);
            o_width_reg  <= trunc_size(L2_W'(s3_w_reg));
            o_height_reg <= trunc_size(L2_W'(s3_h_reg));
            o_class_reg  <= s3_class_reg;
            o_score_reg  <= s3_score_reg;
        end
    end

    assign result.valid      = o_valid_reg;
    assign result.left       = o_left_reg;
    assign result.top        = o_top_reg;
    assign result.box_width  = o_width_reg;
    assign result.box_height = o_height_reg;
    assign result.class_id   = o_class_reg;
    assign result.score      = o_score_reg;

    `DPD_ASSERT_ALWAYS(a_idx_bound, elem_idx_reg <= IDX_W'(MAX_CLASSES + BOX_VALUES - 1), "element index past longest row")
    `DPD_ASSERT_ALWAYS(a_best_nonneg, !best_score_reg[VALUE_W-1], "running best score negative")
    `DPD_ASSERT_NEXT(a_row_restart, acc && row_end, elem_idx_reg == '0 && best_score_reg == '0, "row state not cleared at row end")
    `DPD_ASSERT_NEXT(a_no_spurious, s1_free && !(acc && row_end), !s1_valid_reg, "capture stage loaded without row end")

endmodule

### verif/detection_proposal_decode_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection proposal decode testbench
// Streams detector rows into the decoder and checks every kept detection
// against a local fixed-point decoder. A short table of directed rows covers
// the corner cases. Random rows follow under a series of register settings,
// with random stalls on the input and result channels.
// ----------------------------------------------------------------------------
module detection_proposal_decode_tb;

    import dpd_pkg::*;

    localparam int       Q_FRAC         = 16;
    localparam int       DRAIN_CYCLES   = 8;
    localparam int       WATCHDOG_LIMIT = 1000;
    localparam int       RAND_PHASES    = 12;
    localparam int       PHASE_ITEMS    = 100;
    localparam int       REPORT_LIMIT   = 10;
    localparam cfg_idx_t REG_SPARE      = 3'd7;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t box_width;
        coord_t box_height;
        class_t class_id;
        score_t score;
    } detection_t;

    typedef enum logic [1:0] {STEP_WRITE, STEP_VALUE, STEP_KNOWN} step_kind_t;

    typedef struct {
        step_kind_t kind;
        cfg_idx_t   index;
        cfg_data_t  data;
        value_t     value;
        detection_t want;
    } step_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dpd_cfg_if cfg_bus ();
    dpd_in_if  sample_bus ();
    dpd_out_if result_bus ();

    detection_proposal_decode uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    always #10 clk = ~clk;

    // register shadows
    logic [THRESH_W-1:0] threshold_q = RST_CONF_THRESHOLD;
    logic [PAD_W-1:0]    pad_x_q     = RST_PAD;
    logic [PAD_W-1:0]    pad_y_q     = RST_PAD;
    logic [RATIO_W-1:0]  ratio_x_q   = RST_RATIO;
    logic [RATIO_W-1:0]  ratio_y_q   = RST_RATIO;
    logic [CLASS_W-1:0]  classes_q   = RST_NUM_CLASSES;

    // row decode state
    logic [IDX_W-1:0] elem_idx   = '0;
    longint           best_score = 0;
    class_t           best_class = '0;
    longint           box_cx     = 0;
    longint           box_cy     = 0;
    longint           box_w      = 0;
    longint           box_h      = 0;

    detection_t expected_dets[$];
    step_t      directed_steps[$];
    int         mismatch_count = 0;
    bit         quiet          = 1'b0;

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    // Advances the row by one value; returns 1 when the row ends with a kept box.
    function automatic bit decode_step(input value_t v, output detection_t det);
        longint      val;
        longint      cx;
        longint      cy;
        longint      w;
        longint      h;
        int unsigned last_idx;
        bit          kept;
        val      = longint'(v);
        last_idx = int'(classes_q) + BOX_VALUES - 1;
        det      = '0;
        case (elem_idx)
            9'd0: box_cx = val;
            9'd1: box_cy = val;
            9'd2: box_w  = val;
            9'd3: box_h  = val;
            default:
                if (val > best_score)
                begin
                    best_score = val;
                    best_class = class_t'(elem_idx - BOX_VALUES);
                end
        endcase
        if (elem_idx < last_idx)
        begin
            elem_idx = elem_idx + 1'b1;
            return 1'b0;
        end
        kept = best_score >= longint'(threshold_q);
        if (kept)
        begin
            cx = (box_cx - (longint'(pad_x_q) <<< Q_FRAC)) * longint'(ratio_x_q);
            cy = (box_cy - (longint'(pad_y_q) <<< Q_FRAC)) * longint'(ratio_y_q);
            w  = box_w * longint'(ratio_x_q);
            h  = box_h * longint'(ratio_y_q);
            det.left       = clamp_coord((2 * cx - w) / (64'sd1 <<< (2 * Q_FRAC + 1)));
            det.top        = clamp_coord((2 * cy - h) / (64'sd1 <<< (2 * Q_FRAC + 1)));
            det.box_width  = clamp_coord(w / (64'sd1 <<< (2 * Q_FRAC)));
            det.box_height = clamp_coord(h / (64'sd1 <<< (2 * Q_FRAC)));
            det.class_id   = best_class;
            det.score      = best_score[SCORE_W-1:0];
        end
        elem_idx   = '0;
        best_score = 0;
        best_class = '0;
        return kept;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(16, 60))
                                           : int'($urandom_range(1, 3));
    endfunction

    function automatic value_t random_box();
        if ($urandom_range(0, 3) == 0)
            return value_t'($urandom);
        return value_t'((int'($urandom_range(0, 1100)) - 200) * 65536
                        + int'($urandom_range(0, 65535)));
    endfunction

    function automatic value_t random_score(input value_t prev);
        case ($urandom_range(0, 9))
            0, 1:    return value_t'(-int'($urandom_range(1, 65536)));
            2:       return value_t'($urandom);
            3:       return prev;
            4:       return value_t'(threshold_q) + value_t'(int'($urandom_range(0, 2)) - 1);
            default: return value_t'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input detection_t want,
                                 input detection_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected l=%0d t=%0d w=%0d h=%0d cls=%0d score=%0d, got l=%0d t=%0d w=%0d h=%0d cls=%0d score=%0d",
                     what, $signed(want.left), $signed(want.top), $signed(want.box_width),
                     $signed(want.box_height), want.class_id, want.score,
                     $signed(got.left), $signed(got.top), $signed(got.box_width),
                     $signed(got.box_height), got.class_id, got.score);
    endtask

    task automatic check_detection(input detection_t got);
        detection_t want;
        if (expected_dets.size() == 0)
            flag_mismatch("unexpected detection", '0, got);
        else
        begin
            want = expected_dets.pop_front();
            if (got.left != want.left || got.top != want.top
                || got.box_width != want.box_width || got.box_height != want.box_height
                || got.class_id != want.class_id || got.score != want.score)
                flag_mismatch("detection mismatch", want, got);
        end
    endtask

    // Holds the input off until no detection is pending, then lets extra cycles pass.
    task automatic settle(input int extra);
        sample_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_dets.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_CONF_THRESHOLD: threshold_q = data[THRESH_W-1:0];
            REG_PAD_W:          pad_x_q     = data[PAD_W-1:0];
            REG_PAD_H:          pad_y_q     = data[PAD_W-1:0];
            REG_RATIO_W:        ratio_x_q   = data[RATIO_W-1:0];
            REG_RATIO_H:        ratio_y_q   = data[RATIO_W-1:0];
            REG_NUM_CLASSES:    classes_q   = data[CLASS_W-1:0];
            default:            ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_value(input value_t v, input bit known, input detection_t want);
        int         gap;
        bit         kept;
        detection_t det;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.value <= v;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        kept = decode_step(v, det);
        if (known)
            expected_dets = {expected_dets, want};
        else if (kept)
            expected_dets = {expected_dets, det};
    endtask

    task automatic send_random_row();
        int unsigned len;
        value_t      v;
        value_t      prev;
        len  = int'(classes_q) + BOX_VALUES;
        prev = '0;
        for (int k = 0; k < len; k++)
        begin
            if (k < BOX_VALUES)
                v = random_box();
            else
            begin
                v    = random_score(prev);
                prev = v;
            end
            send_value(v, 1'b0, '0);
        end
    endtask

    task automatic add_write(input cfg_idx_t idx, input cfg_data_t data);
        step_t s;
        s.kind  = STEP_WRITE;
        s.index = idx;
        s.data  = data;
        s.value = '0;
        s.want  = '0;
        directed_steps = {directed_steps, s};
    endtask

    task automatic add_value(input value_t v);
        step_t s;
        s.kind  = STEP_VALUE;
        s.index = '0;
        s.data  = '0;
        s.value = v;
        s.want  = '0;
        directed_steps = {directed_steps, s};
    endtask

    task automatic add_known(input value_t v, input int l, input int t, input int w,
                             input int h, input int cls, input longint sc);
        step_t s;
        s.kind            = STEP_KNOWN;
        s.index           = '0;
        s.data            = '0;
        s.value           = v;
        s.want.left       = coord_t'(l);
        s.want.top        = coord_t'(t);
        s.want.box_width  = coord_t'(w);
        s.want.box_height = coord_t'(h);
        s.want.class_id   = class_t'(cls);
        s.want.score      = score_t'(sc);
        directed_steps = {directed_steps, s};
    endtask

    task automatic build_directed();
        // zero classes: box only, kept at score zero with threshold zero
        add_write(REG_NUM_CLASSES, 24'd0);
        add_write(REG_CONF_THRESHOLD, 24'd0);
        add_value(32'sh0064_0000);
        add_value(32'sh0032_0000);
        add_value(32'sh0014_0000);
        add_known(32'sh000A_0000, 90, 45, 20, 10, 0, 0);
        // full-scale box values and ratio, saturating outputs
        add_write(REG_NUM_CLASSES, 24'd1);
        add_write(REG_RATIO_W, 24'hFF_FFFF);
        add_write(REG_SPARE, 24'hFF_FFFF);
        add_value(32'sh7FFF_FFFF);
        add_value(32'sh8000_0000);
        add_value(32'sh7FFF_FFFF);
        add_value(32'sh8000_0000);
        add_value(32'sh7FFF_FFFF);
        // full-scale threshold, zero ratios, full pads
        add_write(REG_CONF_THRESHOLD, 24'h01_FFFF);
        add_write(REG_PAD_W, 24'hFF_FFFF);
        add_write(REG_PAD_H, 24'd1023);
        add_write(REG_RATIO_W, 24'd0);
        add_write(REG_RATIO_H, 24'd0);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0001_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_value(32'sh0010_0000);
        add_known(32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 64'h7FFF_FFFF);
        // negative score, tie, class count cut mid-row
        add_write(REG_CONF_THRESHOLD, 24'd0);
        add_write(REG_PAD_W, 24'd0);
        add_write(REG_PAD_H, 24'd0);
        add_write(REG_RATIO_W, 24'd65536);
        add_write(REG_RATIO_H, 24'd65536);
        add_write(REG_NUM_CLASSES, 24'd3);
        add_value(32'sh0000_0000);
        add_value(32'sh0000_0000);
        add_value(32'sh0000_0000);
        add_value(32'sh0000_0000);
        add_value(32'shFFFF_FFFF);
        add_value(32'sh0000_0007);
        add_write(REG_NUM_CLASSES, 24'd1);
        add_known(32'sh0000_0007, 0, 0, 0, 0, 1, 7);
    endtask

    task automatic program_phase(input int phase);
        if (phase == RAND_PHASES - 2)
        begin
            write_reg(REG_CONF_THRESHOLD, 24'd0);
            write_reg(REG_PAD_W, 24'd0);
            write_reg(REG_PAD_H, 24'd0);
            write_reg(REG_RATIO_W, 24'd0);
            write_reg(REG_RATIO_H, 24'd0);
            write_reg(REG_NUM_CLASSES, 24'd0);
        end
        else if (phase == RAND_PHASES - 1)
        begin
            write_reg(REG_CONF_THRESHOLD, 24'd65536);
            write_reg(REG_PAD_W, 24'd1023);
            write_reg(REG_PAD_H, 24'd1023);
            write_reg(REG_RATIO_W, 24'hFF_FFFF);
            write_reg(REG_RATIO_H, 24'hFF_FFFF);
            write_reg(REG_NUM_CLASSES, 24'd255);
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       write_reg(REG_CONF_THRESHOLD, cfg_data_t'($urandom));
                1:       write_reg(REG_CONF_THRESHOLD, 24'd0);
                default: write_reg(REG_CONF_THRESHOLD, cfg_data_t'($urandom_range(16384, 65536)));
            endcase
            write_reg(REG_PAD_W, ($urandom_range(0, 3) == 0) ? cfg_data_t'($urandom)
                                                             : cfg_data_t'($urandom_range(0, 1023)));
            write_reg(REG_PAD_H, ($urandom_range(0, 3) == 0) ? cfg_data_t'($urandom)
                                                             : cfg_data_t'($urandom_range(0, 1023)));
            write_reg(REG_RATIO_W, ($urandom_range(0, 3) == 0)
                                   ? cfg_data_t'($urandom)
                                   : cfg_data_t'($urandom_range(16384, 262144)));
            write_reg(REG_RATIO_H, ($urandom_range(0, 3) == 0)
                                   ? cfg_data_t'($urandom)
                                   : cfg_data_t'($urandom_range(16384, 262144)));
            case ($urandom_range(0, 9))
                0:       write_reg(REG_NUM_CLASSES, 24'd0);
                1:       write_reg(REG_NUM_CLASSES, cfg_data_t'($urandom_range(9, 255)));
                default: write_reg(REG_NUM_CLASSES, cfg_data_t'($urandom_range(1, 8)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(cfg_idx_t'($urandom_range(int'(REG_NUM_CLASSES) + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          cfg_data_t'($urandom));
        end
    endtask

    initial
    begin : result_monitor
        int         stall_left;
        int         idle_cycles;
        detection_t got;
        stall_left  = 0;
        idle_cycles = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                got.left       = result_bus.left;
                got.top        = result_bus.top;
                got.box_width  = result_bus.box_width;
                got.box_height = result_bus.box_height;
                got.class_id   = result_bus.class_id;
                got.score      = result_bus.score;
                check_detection(got);
            end
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = pick_gap() - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int items;
        sample_bus.valid <= 1'b0;
        sample_bus.value <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (directed_steps[i])
        begin
            case (directed_steps[i].kind)
                STEP_WRITE:
                begin
                    settle(DRAIN_CYCLES);
                    write_reg(directed_steps[i].index, directed_steps[i].data);
                end
                STEP_VALUE: send_value(directed_steps[i].value, 1'b0, '0);
                STEP_KNOWN: send_value(directed_steps[i].value, 1'b1, directed_steps[i].want);
                default:    ;
            endcase
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            settle(DRAIN_CYCLES);
            quiet = ($urandom_range(0, 3) == 0);
            program_phase(phase);
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle(0);
                send_random_row();
                items += int'(classes_q) + BOX_VALUES;
            end
        end

        settle(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
